// ===== rtl/pbfd_pkg.sv =====
package pbfd_pkg;

   localparam int COEF_FRAC_BITS = 30;

   localparam int SAMPLE_W   = 16;
   localparam int ERR_W      = SAMPLE_W + 1;
   localparam int DIFF_W     = ERR_W + 1;
   localparam int Y_W        = 40;
   localparam int YL_W       = 16;
   localparam int GAIN_W     = 32;
   localparam int ECLAMP_W   = 16;
   localparam int ICLAMP_W   = 31;
   localparam int BAND_W     = 16;
   localparam int DCLAMP_W   = 15;
   localparam int FE_W       = 3;
   localparam int DRIVE_W    = 16;
   localparam int INT_SUM_W  = 51;
   localparam int TRUNC_W    = 48;

   localparam int OPA_W      = 33;
   localparam int OPB_W      = 25;
   localparam int PROD_W     = OPA_W + OPB_W;
   localparam int ACC_W      = 72;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam int STEP_LAST  = 12;
   localparam int STEP_W     = $clog2(STEP_LAST + 1);

   localparam int FE_ERR_CLAMP = 0;
   localparam int FE_SEPARATE  = 1;
   localparam int FE_INT_CLAMP = 2;

   // symmetric rounding of a Q2.30 coefficient down to COEF_FRAC_BITS
   function automatic longint coef_round(input longint c30);
      longint half;
      int     s;
      s = 30 - COEF_FRAC_BITS;
      if (s <= 0) return c30;
      half = longint'(1) << (s - 1);
      if (c30 >= 0) return (c30 + half) >>> s;
      return -(((-c30) + half) >>> s);
   endfunction

   localparam logic signed [OPA_W-1:0] COEF_B0  = OPA_W'(coef_round(72429549));
   localparam logic signed [OPA_W-1:0] COEF_B1  = OPA_W'(coef_round(144859098));
   localparam logic signed [OPA_W-1:0] COEF_B2  = OPA_W'(coef_round(72429549));
   localparam logic signed [OPA_W-1:0] COEF_NA1 = OPA_W'(-coef_round(-1227265970));
   localparam logic signed [OPA_W-1:0] COEF_NA2 = OPA_W'(-coef_round(443242341));

   localparam logic signed [ACC_W-1:0] ACC_RND =
      ACC_W'(longint'(1) << (COEF_FRAC_BITS - 1));

   localparam logic signed [Y_W-1:0] Y_MAX = {1'b0, {(Y_W-1){1'b1}}};
   localparam logic signed [Y_W-1:0] Y_MIN = {1'b1, {(Y_W-1){1'b0}}};

   typedef enum logic [2:0] {
      A_B0, A_B1, A_B2, A_NA1, A_NA2, A_GI, A_GP, A_GD
   } opa_sel_type;

   typedef enum logic [2:0] {
      B_X0, B_X1, B_X2, B_YH1, B_YL1, B_YH2, B_YL2, B_ERR
   } opb_sel_type;

   typedef enum logic [3:0] {
      ACC_HOLD,
      ACC_LOAD_RND_HI,
      ACC_ADD_HI,
      ACC_ADD,
      ACC_LOAD_INT,
      ACC_LOAD,
      ACC_ADD_SHR,
      ACC_ADD_INT,
      ACC_ADD_TRUNC
   } acc_op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN_P          = 3'd0,
      CSR_GAIN_I          = 3'd1,
      CSR_GAIN_D          = 3'd2,
      CSR_ERROR_CLAMP     = 3'd3,
      CSR_INTEGRAL_CLAMP  = 3'd4,
      CSR_SEPARATION_BAND = 3'd5,
      CSR_DRIVE_CLAMP     = 3'd6,
      CSR_FEATURE_ENABLES = 3'd7
   } csr_index_type;

   typedef struct packed {
      opa_sel_type a_sel;
      opb_sel_type b_sel;
      acc_op_type  acc_op;
      logic        cap_err;
      logic        upd_filter;
      logic        upd_int;
      logic        load_out;
   } seq_ctl_type;

endpackage

// ===== rtl/pid_biquad_filtered_derivative.sv =====
// channel   direction  handshake              payload
// req       in         req_tvalid/req_tready  tdata: setpoint[15:0], measured[31:16]
// rsp       out        rsp_tvalid/rsp_tready  tdata: drive[15:0]
// csr       in         csr_we                 csr_index, csr_wdata
//
// A new item is accepted only when the sequencer is idle: all eleven
// products go one per cycle through the single 33x25 multiplier and its accumulator.
// The drive result sits in an output register; a stalled rsp holds the block in its
// final step until the register frees. Reset is synchronous and clears the filter
// and integral state and the registers to their defaults.
module pid_biquad_filtered_derivative (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [31:0]                        req_tdata,   // setpoint, measured
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [15:0]                        rsp_tdata,   // drive
   input  logic                               csr_we,
   input  logic [pbfd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pbfd_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import pbfd_pkg::*;

   seq_ctl_type ctl;
   logic        out_busy;
   logic        req_acc;

   logic [GAIN_W-1:0]   gp_ff, gi_ff, gd_ff;
   logic [ECLAMP_W-1:0] ec_ff;
   logic [ICLAMP_W-1:0] ic_ff;
   logic [BAND_W-1:0]   sb_ff;
   logic [DCLAMP_W-1:0] dc_ff;
   logic [FE_W-1:0]     fe_ff;

   logic signed [ERR_W-1:0]  err_raw_ff, err_raw_in;
   logic signed [ERR_W-1:0]  err_ff, err_in;
   logic signed [DIFF_W-1:0] x0_ff, x0_in;
   logic signed [ERR_W-1:0]  prior_ff;
   logic signed [DIFF_W-1:0] x1_ff, x2_ff;
   logic signed [Y_W-1:0]    y1_ff, y2_ff, y_new;
   logic signed [Y_W-1:0]    ia_ff, ia_in;
   logic signed [DRIVE_W-1:0] drive_ff, drive_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   logic signed [OPA_W-1:0] op_a;
   logic signed [OPB_W-1:0] op_b;
   logic signed [ACC_W-1:0] acc;

   pbfd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .out_busy   (out_busy),
      .req_tready (req_tready),
      .ctl        (ctl)
   );

   pbfd_mac u_mac (
      .clock  (clock),
      .acc_op (ctl.acc_op),
      .op_a   (op_a),
      .op_b   (op_b),
      .integ  (ia_ff),
      .acc    (acc)
   );

   assign req_acc = req_tvalid & req_tready;

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gp_ff <= '0;
         gi_ff <= '0;
         gd_ff <= '0;
         ec_ff <= '1;
         ic_ff <= '1;
         sb_ff <= '1;
         dc_ff <= '1;
         fe_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_GAIN_P:          gp_ff <= csr_wdata[GAIN_W-1:0];
            CSR_GAIN_I:          gi_ff <= csr_wdata[GAIN_W-1:0];
            CSR_GAIN_D:          gd_ff <= csr_wdata[GAIN_W-1:0];
            CSR_ERROR_CLAMP:     ec_ff <= csr_wdata[ECLAMP_W-1:0];
            CSR_INTEGRAL_CLAMP:  ic_ff <= csr_wdata[ICLAMP_W-1:0];
            CSR_SEPARATION_BAND: sb_ff <= csr_wdata[BAND_W-1:0];
            CSR_DRIVE_CLAMP:     dc_ff <= csr_wdata[DCLAMP_W-1:0];
            CSR_FEATURE_ENABLES: fe_ff <= csr_wdata[FE_W-1:0];
         endcase
      end
   end

   // error, optional clamp, raw difference
   logic signed [ERR_W:0] e_wide, ec_wide;
   logic signed [ERR_W:0] mag, band_wide;
   logic                  integrate;

   assign err_raw_in = ERR_W'(signed'(req_tdata[SAMPLE_W-1:0]))
                     - ERR_W'(signed'(req_tdata[2*SAMPLE_W-1:SAMPLE_W]));
   assign e_wide     = (ERR_W+1)'(err_raw_ff);
   assign ec_wide    = signed'((ERR_W+1)'(ec_ff));
   assign x0_in      = DIFF_W'(err_raw_ff) - DIFF_W'(prior_ff);

   always_comb begin
      err_in = err_raw_ff;
      if (fe_ff[FE_ERR_CLAMP]) begin
         if (e_wide >= ec_wide)       err_in = ERR_W'(ec_wide);
         else if (e_wide <= -ec_wide) err_in = ERR_W'(-ec_wide);
      end
   end

   assign mag       = err_ff[ERR_W-1] ? -(ERR_W+1)'(err_ff) : (ERR_W+1)'(err_ff);
   assign band_wide = signed'((ERR_W+1)'(sb_ff));
   assign integrate = !fe_ff[FE_SEPARATE] || (mag <= band_wide);

   always_ff @(posedge clock) begin
      if (req_acc) err_raw_ff <= err_raw_in;
      if (ctl.cap_err) begin
         err_ff <= err_in;
         x0_ff  <= x0_in;
      end
   end

   // operand selection
   always_comb begin
      unique case (ctl.a_sel)
         A_B0:    op_a = COEF_B0;
         A_B1:    op_a = COEF_B1;
         A_B2:    op_a = COEF_B2;
         A_NA1:   op_a = COEF_NA1;
         A_NA2:   op_a = COEF_NA2;
         A_GI:    op_a = signed'(OPA_W'(gi_ff));
         A_GP:    op_a = signed'(OPA_W'(gp_ff));
         A_GD:    op_a = signed'(OPA_W'(gd_ff));
         default: op_a = '0;
      endcase
      unique case (ctl.b_sel)
         B_X0:    op_b = OPB_W'(x0_ff);
         B_X1:    op_b = OPB_W'(x1_ff);
         B_X2:    op_b = OPB_W'(x2_ff);
         B_YH1:   op_b = OPB_W'(signed'(y1_ff[Y_W-1:YL_W]));
         B_YL1:   op_b = signed'(OPB_W'(y1_ff[YL_W-1:0]));
         B_YH2:   op_b = OPB_W'(signed'(y2_ff[Y_W-1:YL_W]));
         B_YL2:   op_b = signed'(OPB_W'(y2_ff[YL_W-1:0]));
         B_ERR:   op_b = OPB_W'(err_ff);
         default: op_b = '0;
      endcase
   end

   // filter output: round to Q.16, saturate
   logic signed [ACC_W-1:0] y_q;
   logic                    y_ovf;

   assign y_q   = acc >>> COEF_FRAC_BITS;
   assign y_ovf = !(&y_q[ACC_W-1:Y_W-1]) && (|y_q[ACC_W-1:Y_W-1]);
   assign y_new = y_ovf ? (y_q[ACC_W-1] ? Y_MIN : Y_MAX) : y_q[Y_W-1:0];

   // integral: saturate, or clamp when enabled
   logic signed [INT_SUM_W-1:0] ia_base, ic_wide;
   logic                        ia_ovf;

   assign ia_base = integrate ? acc[INT_SUM_W-1:0] : INT_SUM_W'(ia_ff);
   assign ic_wide = signed'(INT_SUM_W'(ic_ff));
   assign ia_ovf  = !(&ia_base[INT_SUM_W-1:Y_W-1]) && (|ia_base[INT_SUM_W-1:Y_W-1]);

   always_comb begin
      if (fe_ff[FE_INT_CLAMP]) begin
         if (ia_base >= ic_wide)       ia_in = ic_wide[Y_W-1:0];
         else if (ia_base <= -ic_wide) ia_in = Y_W'(-ic_wide);
         else                          ia_in = ia_base[Y_W-1:0];
      end else if (ia_ovf) begin
         ia_in = ia_base[INT_SUM_W-1] ? Y_MIN : Y_MAX;
      end else begin
         ia_in = ia_base[Y_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prior_ff <= '0;
         x1_ff    <= '0;
         x2_ff    <= '0;
         y1_ff    <= '0;
         y2_ff    <= '0;
         ia_ff    <= '0;
      end else begin
         if (ctl.upd_filter) begin
            prior_ff <= err_ff;
            x1_ff    <= x0_ff;
            x2_ff    <= x1_ff;
            y1_ff    <= y_new;
            y2_ff    <= y1_ff;
         end
         if (ctl.upd_int) ia_ff <= ia_in;
      end
   end

   // drive: truncated sum clamped to the drive bound
   logic signed [TRUNC_W-1:0] t_sum, dc_wide;

   assign t_sum   = signed'(acc[TRUNC_W+15:16]);
   assign dc_wide = signed'(TRUNC_W'(dc_ff));

   always_comb begin
      if (t_sum >= dc_wide)       drive_in = dc_wide[DRIVE_W-1:0];
      else if (t_sum <= -dc_wide) drive_in = DRIVE_W'(-dc_wide);
      else                        drive_in = t_sum[DRIVE_W-1:0];
   end

   assign out_busy     = rsp_valid_ff & ~rsp_tready;
   assign rsp_valid_in = ctl.load_out | out_busy;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
      if (ctl.load_out) drive_ff <= drive_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = drive_ff;

endmodule

// ===== rtl/pbfd_mac.sv =====
module pbfd_mac (
   input  logic                                clock,
   input  pbfd_pkg::acc_op_type                acc_op,
   input  logic signed [pbfd_pkg::OPA_W-1:0]   op_a,
   input  logic signed [pbfd_pkg::OPB_W-1:0]   op_b,
   input  logic signed [pbfd_pkg::Y_W-1:0]     integ,
   output logic signed [pbfd_pkg::ACC_W-1:0]   acc
);
   import pbfd_pkg::*;

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [ACC_W-1:0]  base, addend;
   logic signed [ACC_W-1:0]  prod_ext, prod_hi, prod_lo, integ_ext, bias;

   assign prod_in   = op_a * op_b;
   assign prod_ext  = ACC_W'(prod_ff);
   assign prod_hi   = signed'(ACC_W'({prod_ff, 16'h0000}));
   assign prod_lo   = prod_ext >>> 16;
   assign integ_ext = ACC_W'(integ);
   // bias so that the following shift truncates toward zero
   assign bias      = acc_ff[ACC_W-1] ? signed'(ACC_W'(16'hFFFF)) : '0;

   always_comb begin
      base   = acc_ff;
      addend = '0;
      unique case (acc_op)
         ACC_HOLD: begin
            base   = acc_ff;
            addend = '0;
         end
         ACC_LOAD_RND_HI: begin
            base   = ACC_RND;
            addend = prod_hi;
         end
         ACC_ADD_HI: begin
            addend = prod_hi;
         end
         ACC_ADD: begin
            addend = prod_ext;
         end
         ACC_LOAD_INT: begin
            base   = integ_ext;
            addend = prod_ext;
         end
         ACC_LOAD: begin
            base   = '0;
            addend = prod_ext;
         end
         ACC_ADD_SHR: begin
            addend = prod_lo;
         end
         ACC_ADD_INT: begin
            addend = integ_ext;
         end
         ACC_ADD_TRUNC: begin
            addend = bias;
         end
         default: begin
            base   = acc_ff;
            addend = '0;
         end
      endcase
      acc_in = base + addend;
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign acc = acc_ff;

endmodule

// ===== rtl/pbfd_ctrl.sv =====
module pbfd_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  out_busy,
   output logic                  req_tready,
   output pbfd_pkg::seq_ctl_type ctl
);
   import pbfd_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_DIFF  = 5'b00010,
      ST_RUN   = 5'b00100,
      ST_TRUNC = 5'b01000,
      ST_CLAMP = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   always_comb begin
      state_in       = state_ff;
      step_in        = step_ff;
      ctl.a_sel      = A_GD;
      ctl.b_sel      = B_ERR;
      ctl.acc_op     = ACC_HOLD;
      ctl.cap_err    = 1'b0;
      ctl.upd_filter = 1'b0;
      ctl.upd_int    = 1'b0;
      ctl.load_out   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_DIFF;
         end
         ST_DIFF: begin
            ctl.cap_err = 1'b1;
            step_in     = '0;
            state_in    = ST_RUN;
         end
         ST_RUN: begin
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(STEP_LAST)) state_in = ST_TRUNC;
            // multiply issued this step, accumulate the one issued last step
            unique case (step_ff)
               STEP_W'(0): begin
                  ctl.a_sel = A_B0;  ctl.b_sel = B_X0;
               end
               STEP_W'(1): begin
                  ctl.a_sel = A_B1;  ctl.b_sel = B_X1;  ctl.acc_op = ACC_LOAD_RND_HI;
               end
               STEP_W'(2): begin
                  ctl.a_sel = A_B2;  ctl.b_sel = B_X2;  ctl.acc_op = ACC_ADD_HI;
               end
               STEP_W'(3): begin
                  ctl.a_sel = A_NA1; ctl.b_sel = B_YH1; ctl.acc_op = ACC_ADD_HI;
               end
               STEP_W'(4): begin
                  ctl.a_sel = A_NA1; ctl.b_sel = B_YL1; ctl.acc_op = ACC_ADD_HI;
               end
               STEP_W'(5): begin
                  ctl.a_sel = A_NA2; ctl.b_sel = B_YH2; ctl.acc_op = ACC_ADD;
               end
               STEP_W'(6): begin
                  ctl.a_sel = A_NA2; ctl.b_sel = B_YL2; ctl.acc_op = ACC_ADD_HI;
               end
               STEP_W'(7): begin
                  ctl.a_sel = A_GI;  ctl.b_sel = B_ERR; ctl.acc_op = ACC_ADD;
               end
               STEP_W'(8): begin
                  ctl.a_sel = A_GP;  ctl.b_sel = B_ERR; ctl.acc_op = ACC_LOAD_INT;
                  ctl.upd_filter = 1'b1;
               end
               STEP_W'(9): begin
                  ctl.a_sel = A_GD;  ctl.b_sel = B_YH1; ctl.acc_op = ACC_LOAD;
                  ctl.upd_int = 1'b1;
               end
               STEP_W'(10): begin
                  ctl.a_sel = A_GD;  ctl.b_sel = B_YL1; ctl.acc_op = ACC_ADD;
               end
               STEP_W'(11): begin
                  ctl.acc_op = ACC_ADD_SHR;
               end
               STEP_W'(12): begin
                  ctl.acc_op = ACC_ADD_INT;
               end
               default: begin
                  ctl.acc_op = ACC_HOLD;
               end
            endcase
         end
         ST_TRUNC: begin
            ctl.acc_op = ACC_ADD_TRUNC;
            state_in   = ST_CLAMP;
         end
         ST_CLAMP: begin
            if (!out_busy) begin
               ctl.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);

endmodule
